// ----- rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants of the matrix multiply-accumulate block
// Holds the field widths and the structure that carries one A operand along
// the chain of MAC cells.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int ELEM_W   = 16;	// Q8.8 operands
	localparam int CIN_W    = 32;	// Q16.16 initial C
	localparam int PROD_W   = 32;	// exact product of two Q8.8 values
	localparam int ACC_W    = 36;	// sum of up to eight products, never overflows
	localparam int RES_W    = 40;	// Q24.16 result
	localparam int RIDX_W   = 6;	// row-major result position
	localparam int SIZE_W   = 4;	// matrix_size register
	localparam int KIDX_MAX = 3;	// index width into a cell's column store (up to 8 rows)

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// One A operand travelling down the chain, tagged with its inner index k.
	typedef struct packed {
		logic                v;
		logic [KIDX_MAX-1:0] k;
		elem_t               a;
	} feed_t;

endpackage

// ----- rtl/mma_cell.sv -----
// ----------------------------------------------------------------------------
// mma_cell: one multiply-accumulate cell of the chain
// Holds one column of B and the running sum of one C element of the current
// row; passes its A operand on to the next cell every cycle.
// ----------------------------------------------------------------------------
module mma_cell import mma_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                b_we,
	input  logic [KIDX_MAX-1:0] b_k,
	input  elem_t               b_data,
	input  feed_t               feed_in,
	output feed_t               feed_out,
	output acc_t                acc
);

	localparam int KW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	elem_t               col_q [DEPTH];
	logic                feed_v_q;
	logic [KIDX_MAX-1:0] feed_k_q;
	elem_t               feed_a_q;
	acc_t                acc_q;
	logic signed [PROD_W-1:0] prod;

	// Column store of B, one entry per inner index.
	always_ff @(posedge clk) begin
		if (b_we) begin
			col_q[b_k[KW-1:0]] <= b_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_v_q <= 1'b0;
		end else begin
			feed_v_q <= feed_in.v;
		end
	end

	always_ff @(posedge clk) begin
		feed_k_q <= feed_in.k;
		feed_a_q <= feed_in.a;
	end

	assign prod = feed_a_q * col_q[feed_k_q[KW-1:0]];

	always_ff @(posedge clk) begin
		if (clr) begin
			acc_q <= '0;
		end else if (feed_v_q) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		end
	end

	assign feed_out.v = feed_v_q;
	assign feed_out.k = feed_k_q;
	assign feed_out.a = feed_a_q;
	assign acc        = acc_q;

endmodule

// ----- rtl/matrix_multiply_accumulate.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: square matrix C = C + A*B in fixed point
// Loads A, B and C element by element in row-major order, then computes the
// result row by row on a chain of MAC cells and returns it in row-major order.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake            Payload
//  -------  ---  -------------------  ------------------------------------
//  in       in   in_valid / in_stall  a_element, b_element, c_element
//  out      out  out_valid/ out_stall c_result, result_index, last_result
//  cfg      in   cfg_valid/ cfg_ready cfg_data (matrix_size)
//
// Loading accepts input beats while in_stall is low. Once the n*n-th beat is
// in, the columns of B are copied from the B store into the cells, then each
// row is computed on the chain, followed by its output beats, each of which
// passes through the read, calculate and wait states. The input is stalled
// from the last load beat until the final result beat has been taken. Reset
// clears the size register to MAX_SIZE and the load count to zero; the stores
// are not cleared. A stall on the output simply holds the current result beat.
//
module matrix_multiply_accumulate import mma_pkg::*; #(
	parameter int MAX_SIZE = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [ELEM_W-1:0] a_element,
	input  logic signed [ELEM_W-1:0] b_element,
	input  logic signed [CIN_W-1:0]  c_element,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [RES_W-1:0]  c_result,
	output logic [RIDX_W-1:0]        result_index,
	output logic                     last_result,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [SIZE_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int NW    = $clog2(MAX_SIZE + 1);
	localparam int LW    = 2 * NW;
	localparam int TW    = $clog2(2 * MAX_SIZE + 2);

	typedef enum logic [2:0] {
		S_LOAD, S_BFILL, S_MAC, S_OUT_RD, S_OUT_CALC, S_OUT_WAIT
	} state_t;

	state_t                  state_q;
	logic [SIZE_W-1:0]       size_q;
	logic [LW-1:0]           load_count_q;
	logic [KW-1:0]           n_m1_q;
	logic [NW-1:0]           n_act;
	logic [LW-1:0]           total;
	logic                    in_acc;
	logic                    out_acc;
	logic                    load_done;

	// Stores of the loaded matrices.
	elem_t                   a_mem [DEPTH];
	elem_t                   b_mem [DEPTH];
	logic signed [CIN_W-1:0] c_mem [DEPTH];
	logic [AW-1:0]           wr_addr;

	// B column transfer counters and read pipeline.
	logic [KW-1:0]           bk_q, bj_q;
	logic [AW-1:0]           baddr_q;
	logic                    bv_s1;
	logic [KW-1:0]           bk_s1, bj_s1;
	elem_t                   b_rd_s1;

	// Row sequencing.
	logic [KW-1:0]           i_q, j_q;
	logic [TW-1:0]           t_q;
	logic [AW-1:0]           row_base_q;
	logic                    a_issue;
	logic [AW-1:0]           a_raddr;
	logic                    av_s1;
	logic [KW-1:0]           ak_s1;
	elem_t                   a_rd_s1;
	logic [AW-1:0]           c_raddr;
	logic signed [CIN_W-1:0] c_rd_s1;
	logic                    clr;

	feed_t                   feed [MAX_SIZE+1];
	acc_t                    accs [MAX_SIZE];
	acc_t                    acc_sel;

	logic signed [RES_W-1:0] res_q;
	logic [RIDX_W-1:0]       ridx_q;
	logic                    last_q;
	logic                    ovalid_q;

	// ------------------------------------------------------------------
	// Configuration: a single register, always ready.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_SIZE);
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	// Out-of-range sizes are clamped: zero acts as one, anything above the
	// built-in maximum acts as the maximum.
	always_comb begin
		priority if (size_q == '0) begin
			n_act = NW'(1);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n_act = NW'(MAX_SIZE);
		end else begin
			n_act = NW'(size_q);
		end
	end

	assign total     = LW'(n_act) * LW'(n_act);
	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = ovalid_q && !out_stall;
	// The size in force now decides completion, so a shrink during loading
	// ends the load with the next accepted beat.
	assign load_done = (load_count_q + LW'(1)) >= total;
	assign wr_addr   = load_count_q[AW-1:0];

	// ------------------------------------------------------------------
	// Stores: written while loading, read one address per cycle each.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_mem[wr_addr] <= a_element;
			b_mem[wr_addr] <= b_element;
			c_mem[wr_addr] <= c_element;
		end
		a_rd_s1 <= a_mem[a_raddr];
		b_rd_s1 <= b_mem[baddr_q];
		c_rd_s1 <= c_mem[c_raddr];
	end

	assign a_issue = (state_q == S_MAC) && (t_q <= TW'(n_m1_q));
	assign a_raddr = row_base_q + AW'(t_q);
	assign c_raddr = row_base_q + AW'(j_q);
	assign clr     = (state_q == S_MAC) && (t_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s1 <= 1'b0;
			av_s1 <= 1'b0;
		end else begin
			bv_s1 <= (state_q == S_BFILL);
			av_s1 <= a_issue;
		end
	end

	always_ff @(posedge clk) begin
		bk_s1 <= bk_q;
		bj_s1 <= bj_q;
		ak_s1 <= KW'(t_q);
	end

	// ------------------------------------------------------------------
	// Chain of MAC cells. Cell j accumulates C[i][j]; the A operands of row
	// i enter cell 0 and move one cell along each cycle.
	// ------------------------------------------------------------------
	assign feed[0].v = av_s1;
	assign feed[0].k = KIDX_MAX'(ak_s1);
	assign feed[0].a = a_rd_s1;

	for (genvar g = 0; g < MAX_SIZE; g++) begin : g_cell
		mma_cell #(.DEPTH(MAX_SIZE)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (clr),
			.b_we    (bv_s1 && (bj_s1 == KW'(g))),
			.b_k     (KIDX_MAX'(bk_s1)),
			.b_data  (b_rd_s1),
			.feed_in (feed[g]),
			.feed_out(feed[g+1]),
			.acc     (accs[g])
		);
	end

	assign acc_sel = accs[j_q];

	// ------------------------------------------------------------------
	// Sequencer: load, B transfer, row computation and result beats.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			load_count_q <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_done) begin
							load_count_q <= '0;
							n_m1_q       <= KW'(n_act - NW'(1));
							bk_q         <= '0;
							bj_q         <= '0;
							baddr_q      <= '0;
							state_q      <= S_BFILL;
						end else begin
							load_count_q <= load_count_q + LW'(1);
						end
					end
				end
				S_BFILL: begin
					baddr_q <= baddr_q + AW'(1);
					if (bj_q == n_m1_q) begin
						bj_q <= '0;
						if (bk_q == n_m1_q) begin
							i_q        <= '0;
							row_base_q <= '0;
							t_q        <= '0;
							state_q    <= S_MAC;
						end else begin
							bk_q <= bk_q + KW'(1);
						end
					end else begin
						bj_q <= bj_q + KW'(1);
					end
				end
				S_MAC: begin
					if (t_q == TW'({n_m1_q, 1'b1}) + TW'(1)) begin
						j_q     <= '0;
						state_q <= S_OUT_RD;
					end else begin
						t_q <= t_q + TW'(1);
					end
				end
				S_OUT_RD: begin
					state_q <= S_OUT_CALC;
				end
				S_OUT_CALC: begin
					res_q    <= {{(RES_W-CIN_W){c_rd_s1[CIN_W-1]}}, c_rd_s1}
						+ {{(RES_W-ACC_W){acc_sel[ACC_W-1]}}, acc_sel};
					ridx_q   <= RIDX_W'(c_raddr);
					last_q   <= (i_q == n_m1_q) && (j_q == n_m1_q);
					ovalid_q <= 1'b1;
					state_q  <= S_OUT_WAIT;
				end
				S_OUT_WAIT: begin
					if (out_acc) begin
						ovalid_q <= 1'b0;
						if (j_q == n_m1_q) begin
							if (i_q == n_m1_q) begin
								state_q <= S_LOAD;
							end else begin
								i_q        <= i_q + KW'(1);
								row_base_q <= row_base_q + AW'(n_m1_q) + AW'(1);
								t_q        <= '0;
								state_q    <= S_MAC;
							end
						end else begin
							j_q     <= j_q + KW'(1);
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign c_result     = res_q;
	assign result_index = ridx_q;
	assign last_result  = last_q;

`ifndef SYNTH
	// No input beat is taken while a result beat is still on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall))
		else $error("input accepted while a result is pending");

	// Once the final result beat is taken, loading resumes straight away.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_result) |=> !in_stall)
		else $error("block did not return to loading after the last result");

	// The load count never runs past the largest matrix.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_count_q < LW'(DEPTH))
		else $error("load count out of range");
`endif

endmodule
